### src/dtf_pkg.sv
// Package for the degenerate triangle filter: verdict codes, register
// indexes, reset values and default widths. No dependencies.
`default_nettype none

package dtf_pkg;

  localparam int CoordBitsDef = 24;
  localparam int IndexBitsDef = 24;
  localparam int ThrBits      = 32;
  localparam int CfgIdxBits   = 2;

  localparam logic [CfgIdxBits-1:0] CfgStraight = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgReversed = 2'd1;

  localparam logic [ThrBits-1:0] StraightReset = 32'd1074;
  localparam logic [ThrBits-1:0] ReversedReset = 32'd1509;

  typedef enum logic [1:0] {
    VerdictKeep     = 2'd0,
    VerdictStraight = 2'd1,
    VerdictReversed = 2'd2,
    VerdictRepeat   = 2'd3
  } verdict_e;

endpackage

`default_nettype wire

### src/degenerate_triangle_filter_unit.sv
// Degenerate triangle filter, top level: nine-stage pipeline with exact
// integer angle test and repeated-index test. Depends on dtf_pkg.
`default_nettype none

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | index_a/b/c_i, ax..cz_i
//  out     | output    | out_valid_o/out_stall_i | keep_o, verdict_o
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  One beat per cycle sustained while out_stall_i is low. The multiplier chain
//  runs products, squared norms, norm product, threshold product, compare.
//  Each stage holds while the stage after it is full and stalled; empty stages
//  fill, so bubbles close up. Reset empties the pipeline and loads the default
//  thresholds.

module degenerate_triangle_filter_unit #(
  parameter int COORD_BITS = dtf_pkg::CoordBitsDef,
  parameter int INDEX_BITS = dtf_pkg::IndexBitsDef
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire        [INDEX_BITS-1:0]           index_a_i,
  input  wire        [INDEX_BITS-1:0]           index_b_i,
  input  wire        [INDEX_BITS-1:0]           index_c_i,
  input  wire signed [COORD_BITS-1:0]           ax_i,
  input  wire signed [COORD_BITS-1:0]           ay_i,
  input  wire signed [COORD_BITS-1:0]           az_i,
  input  wire signed [COORD_BITS-1:0]           bx_i,
  input  wire signed [COORD_BITS-1:0]           by_coord_i,
  input  wire signed [COORD_BITS-1:0]           bz_i,
  input  wire signed [COORD_BITS-1:0]           cx_i,
  input  wire signed [COORD_BITS-1:0]           cy_i,
  input  wire signed [COORD_BITS-1:0]           cz_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  keep_o,
  output logic       [1:0]                      verdict_o,
  input  wire                                   cfg_we_i,
  input  wire        [dtf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire        [dtf_pkg::ThrBits-1:0]     cfg_data_i
);

  localparam int NS = 9;
  localparam int TW = dtf_pkg::ThrBits;
  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * DW;
  localparam int HW = DW;
  localparam int PW = 2 * MW;
  localparam int NL = (PW + TW - 1) / TW;
  localparam int AW = NL * TW + TW;

  logic [TW-1:0] str_q, rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q <= dtf_pkg::StraightReset;
      rev_q <= dtf_pkg::ReversedReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dtf_pkg::CfgStraight: str_q <= cfg_data_i;
        dtf_pkg::CfgReversed: rev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NS:1]   vld_q;
  logic [NS-1:0] vin;
  logic [NS+1:1] rdy;
  logic [NS:1]   en;

  always_comb begin
    vin = {vld_q[NS-1:1], in_valid_i};
    rdy[NS+1] = !out_stall_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 1; k <= NS; k++) begin
      en[k] = rdy[k] && vin[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = vld_q[NS];

  // stage 1: edge vectors, repeated index
  logic signed [DW-1:0] u1_q [3];
  logic signed [DW-1:0] v1_q [3];
  logic                 dup1_q;
  logic signed [COORD_BITS-1:0] ca [3];
  logic signed [COORD_BITS-1:0] cb [3];
  logic signed [COORD_BITS-1:0] cc [3];

  always_comb begin
    ca[0] = ax_i; ca[1] = ay_i;       ca[2] = az_i;
    cb[0] = bx_i; cb[1] = by_coord_i; cb[2] = bz_i;
    cc[0] = cx_i; cc[1] = cy_i;       cc[2] = cz_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        u1_q[k] <= {ca[k][COORD_BITS-1], ca[k]} - {cb[k][COORD_BITS-1], cb[k]};
        v1_q[k] <= {cb[k][COORD_BITS-1], cb[k]} - {cc[k][COORD_BITS-1], cc[k]};
      end
      dup1_q <= (index_a_i == index_b_i) || (index_a_i == index_c_i) ||
                (index_b_i == index_c_i);
    end
  end

  // stage 2: per-axis products
  logic signed [MW-1:0] pu2_q [3];
  logic signed [MW-1:0] pv2_q [3];
  logic signed [MW-1:0] pd2_q [3];
  logic                 dup2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pu2_q[k] <= MW'(u1_q[k]) * MW'(u1_q[k]);
        pv2_q[k] <= MW'(v1_q[k]) * MW'(v1_q[k]);
        pd2_q[k] <= MW'(u1_q[k]) * MW'(v1_q[k]);
      end
      dup2_q <= dup1_q;
    end
  end

  // stage 3: squared norms and dot product
  logic        [MW-1:0] uu3_q, vv3_q;
  logic signed [MW:0]   dt3_q;
  logic                 dup3_q;
  logic signed [MW:0]   s_uu, s_vv, s_dt;

  always_comb begin
    s_uu = (MW+1)'(pu2_q[0]) + (MW+1)'(pu2_q[1]) + (MW+1)'(pu2_q[2]);
    s_vv = (MW+1)'(pv2_q[0]) + (MW+1)'(pv2_q[1]) + (MW+1)'(pv2_q[2]);
    s_dt = (MW+1)'(pd2_q[0]) + (MW+1)'(pd2_q[1]) + (MW+1)'(pd2_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      uu3_q  <= s_uu[MW-1:0];
      vv3_q  <= s_vv[MW-1:0];
      dt3_q  <= s_dt;
      dup3_q <= dup2_q;
    end
  end

  // stage 4: dot magnitude and sign, zero-edge detect
  logic [MW-1:0]      uu4_q, vv4_q, dm4_q;
  logic               neg4_q, nz4_q, dup4_q;
  logic signed [MW:0] dt_neg;

  assign dt_neg = -dt3_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      uu4_q  <= uu3_q;
      vv4_q  <= vv3_q;
      dm4_q  <= dt3_q[MW] ? dt_neg[MW-1:0] : dt3_q[MW-1:0];
      neg4_q <= dt3_q[MW];
      nz4_q  <= (uu3_q != '0) && (vv3_q != '0);
      dup4_q <= dup3_q;
    end
  end

  // stage 5: half-word partial products of uu*vv and dot^2
  logic [MW-1:0] phh5_q, phl5_q, plh5_q, pll5_q;
  logic [MW-1:0] dhh5_q, dx5_q, dll5_q;
  logic          neg5_q, nz5_q, dup5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      phh5_q <= MW'(uu4_q[MW-1:HW]) * MW'(vv4_q[MW-1:HW]);
      phl5_q <= MW'(uu4_q[MW-1:HW]) * MW'(vv4_q[HW-1:0]);
      plh5_q <= MW'(uu4_q[HW-1:0])  * MW'(vv4_q[MW-1:HW]);
      pll5_q <= MW'(uu4_q[HW-1:0])  * MW'(vv4_q[HW-1:0]);
      dhh5_q <= MW'(dm4_q[MW-1:HW]) * MW'(dm4_q[MW-1:HW]);
      dx5_q  <= MW'(dm4_q[MW-1:HW]) * MW'(dm4_q[HW-1:0]);
      dll5_q <= MW'(dm4_q[HW-1:0])  * MW'(dm4_q[HW-1:0]);
      neg5_q <= neg4_q;
      nz5_q  <= nz4_q;
      dup5_q <= dup4_q;
    end
  end

  // stage 6: norm product and squared dot
  logic [PW-1:0] p6_q, d6_q;
  logic          neg6_q, nz6_q, dup6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      p6_q   <= {phh5_q, pll5_q} + (PW'(phl5_q) << HW) + (PW'(plh5_q) << HW);
      d6_q   <= {dhh5_q, dll5_q} + (PW'(dx5_q) << (HW + 1));
      neg6_q <= neg5_q;
      nz6_q  <= nz5_q;
      dup6_q <= dup5_q;
    end
  end

  // stage 7: squared cross norm, limb products of the threshold term
  logic [PW-1:0]     cr7_q;
  logic [2*TW-1:0]   pt7_q [NL];
  logic              neg7_q, nz7_q, dup7_q;
  logic [TW-1:0]     thr;
  logic [NL*TW-1:0]  p_pad;

  assign thr   = neg6_q ? rev_q : str_q;
  assign p_pad = (NL*TW)'(p6_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      cr7_q <= p6_q - d6_q;
      for (int i = 0; i < NL; i++) begin
        pt7_q[i] <= (2*TW)'(p_pad[i*TW +: TW]) * (2*TW)'(thr);
      end
      neg7_q <= neg6_q;
      nz7_q  <= nz6_q;
      dup7_q <= dup6_q;
    end
  end

  // stage 8: assemble threshold term
  logic [PW-1:0] cr8_q;
  logic [AW-1:0] rhs8_q;
  logic          neg8_q, nz8_q, dup8_q;
  logic [AW-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NL; i++) begin
      acc = acc + (AW'(pt7_q[i]) << (i * TW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      cr8_q  <= cr7_q;
      rhs8_q <= acc;
      neg8_q <= neg7_q;
      nz8_q  <= nz7_q;
      dup8_q <= dup7_q;
    end
  end

  // stage 9: compare and verdict, output register
  logic              keep_q;
  dtf_pkg::verdict_e verdict_q;
  logic              thin;
  dtf_pkg::verdict_e verdict_d;

  assign thin = nz8_q && (AW'({cr8_q, {TW{1'b0}}}) < rhs8_q);

  always_comb begin
    if (thin) begin
      verdict_d = neg8_q ? dtf_pkg::VerdictReversed : dtf_pkg::VerdictStraight;
    end else if (dup8_q) begin
      verdict_d = dtf_pkg::VerdictRepeat;
    end else begin
      verdict_d = dtf_pkg::VerdictKeep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      verdict_q <= verdict_d;
      keep_q    <= !thin && !dup8_q;
    end
  end

  assign keep_o    = keep_q;
  assign verdict_o = verdict_q;

  a_keep_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (keep_o == (verdict_q == dtf_pkg::VerdictKeep)))
    else $error("keep disagrees with verdict");

  a_cauchy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (p6_q >= d6_q))
    else $error("squared dot exceeds norm product");

  a_zero_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[9] && !nz8_q) |=> (verdict_q != dtf_pkg::VerdictStraight &&
                           verdict_q != dtf_pkg::VerdictReversed))
    else $error("angle cull on zero-length edge");

  a_reversed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[9] && !neg8_q) |=> (verdict_q != dtf_pkg::VerdictReversed))
    else $error("reversed verdict with nonnegative dot");

endmodule

`default_nettype wire
